>>> sv/sfa_pkg.sv
`default_nettype none

package sfa_pkg;

    // Field widths of the request and response items
    localparam int OPCODE_W = 2;
    localparam int SIZE_W   = 21;
    localparam int ALIGN_W  = 4;
    localparam int STATUS_W = 2;
    localparam int OFFS_W   = 21;

    // Working widths: rounded size and the bound-check sum
    localparam int ROUND_W  = OFFS_W + 1;
    localparam int SUM_W    = OFFS_W + 2;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 21;
    localparam logic [CFG_DATA_W-1:0] STACK_SIZE_RST = CFG_DATA_W'(65536);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STACK_SIZE = 1'b0,
        CFG_SEAMLESS   = 1'b1
    } t_cfg_idx;

    typedef enum logic [OPCODE_W-1:0] {
        OP_ALLOC   = 2'd0,
        OP_POP     = 2'd1,
        OP_RELEASE = 2'd2,
        OP_NONE    = 2'd3
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_NO_SPACE = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_UNUSED   = 2'd3
    } t_status;

    // Controller -> datapath commands
    typedef struct packed {
        logic exec;        // run a request that needs no store read and load the result
        logic pop_read;    // start a frame pop: read the store, drop the count
        logic pop_finish;  // finish the frame pop from the read data
    } t_cmd;

    // Datapath -> controller status
    typedef struct packed {
        logic pop_deferred; // the pending request needs a frame store read
    } t_stat;

endpackage

`default_nettype wire

>>> sv/sfa_req_if.sv
`default_nettype none

interface sfa_req_if;
    logic                         valid;
    logic                         ready;
    logic [sfa_pkg::OPCODE_W-1:0] opcode;
    logic [sfa_pkg::SIZE_W-1:0]   size;
    logic [sfa_pkg::ALIGN_W-1:0]  align_log2;

    modport source (output valid, output opcode, output size, output align_log2,
                    input ready);
    modport sink   (input valid, input opcode, input size, input align_log2,
                    output ready);
endinterface

`default_nettype wire

>>> sv/sfa_rsp_if.sv
`default_nettype none

interface sfa_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [sfa_pkg::STATUS_W-1:0] status;
    logic [sfa_pkg::OFFS_W-1:0]   offset;
    logic [sfa_pkg::OFFS_W-1:0]   top;

    modport source (output valid, output status, output offset, output top,
                    input ready);
    modport sink   (input valid, input status, input offset, input top,
                    output ready);
endinterface

`default_nettype wire

>>> sv/sfa_ram.sv
`default_nettype none

module sfa_ram #(
    parameter int WIDTH = 21,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> sv/sfa_ctrl.sv
`default_nettype none

module sfa_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    input  wire sfa_pkg::t_stat i_stat,
    output sfa_pkg::t_cmd       o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_POP
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;
    logic   accept;

    // Output register is free when empty or being drained this cycle
    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && out_free;
    assign accept     = i_in_valid && o_in_ready;

    // Commands to the datapath
    always_comb begin
        o_cmd.exec       = accept && !i_stat.pop_deferred;
        o_cmd.pop_read   = accept && i_stat.pop_deferred;
        o_cmd.pop_finish = (r_state == S_POP) && out_free;
    end

    // Next state and output-valid
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (o_cmd.pop_read) begin
                    n_state = S_POP;
                end
            end
            S_POP: begin
                if (o_cmd.pop_finish) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (o_cmd.exec || o_cmd.pop_finish) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

>>> sv/sfa_dp.sv
`default_nettype none

module sfa_dp #(
    parameter int HEADER_BYTES = 8,
    parameter int MAX_FRAMES   = 1024
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [sfa_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [sfa_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic [sfa_pkg::OPCODE_W-1:0]   i_opcode,
    input  wire logic [sfa_pkg::SIZE_W-1:0]     i_size,
    input  wire logic [sfa_pkg::ALIGN_W-1:0]    i_align_log2,
    input  wire sfa_pkg::t_cmd                  i_cmd,
    output sfa_pkg::t_stat                      o_stat,
    output logic [sfa_pkg::STATUS_W-1:0]        o_status,
    output logic [sfa_pkg::OFFS_W-1:0]          o_offset,
    output logic [sfa_pkg::OFFS_W-1:0]          o_top
);

    localparam int AW = $clog2(MAX_FRAMES);
    localparam int CW = $clog2(MAX_FRAMES + 1);
    localparam int OW = sfa_pkg::OFFS_W;
    localparam int RW = sfa_pkg::ROUND_W;
    localparam int SW = sfa_pkg::SUM_W;

    // Configuration and stack state
    logic [sfa_pkg::CFG_DATA_W-1:0] r_stack_size;
    logic                           r_seamless;
    logic [OW-1:0]                  r_top;
    logic [CW-1:0]                  r_count;

    // Result registers
    logic [sfa_pkg::STATUS_W-1:0]   r_status;
    logic [OW-1:0]                  r_offset;
    logic [OW-1:0]                  r_res_top;

    sfa_pkg::t_opcode op;
    logic [RW-1:0]    mask;
    logic [RW-1:0]    rounded;
    logic [SW-1:0]    hdr;
    logic [SW-1:0]    sum;
    logic             fits;
    logic             full;
    logic             alloc_ok;
    logic             push;
    logic [CW-1:0]    count_dec;
    logic [OW-1:0]    rd_data;

    assign op = sfa_pkg::t_opcode'(i_opcode);

    // Allocate: round up to alignment and add header (not in seamless mode), bound check
    always_comb begin
        mask     = (RW'(1) << i_align_log2) - RW'(1);
        rounded  = r_seamless ? RW'(i_size) : ((RW'(i_size) + mask) & ~mask);
        hdr      = r_seamless ? '0 : SW'(HEADER_BYTES);
        sum      = SW'(r_top) + SW'(rounded) + hdr;
        fits     = sum < SW'(r_stack_size);
        full     = !r_seamless && (r_count == CW'(MAX_FRAMES));
        alloc_ok = !full && fits;
        push     = i_cmd.exec && (op == sfa_pkg::OP_ALLOC) && alloc_ok && !r_seamless;
    end

    assign count_dec = r_count - CW'(1);

    // A pop defers to a store read only when a saved frame exists and seamless mode is off
    assign o_stat.pop_deferred = (op == sfa_pkg::OP_POP) && !r_seamless
                                 && (r_count != '0);

    // Frame store
    sfa_ram #(
        .WIDTH (OW),
        .DEPTH (MAX_FRAMES)
    ) u_frames (
        .i_clk   (i_clk),
        .i_we    (push),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (r_top),
        .i_re    (i_cmd.pop_read),
        .i_raddr (count_dec[AW-1:0]),
        .o_rdata (rd_data)
    );

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stack_size <= sfa_pkg::STACK_SIZE_RST;
            r_seamless   <= 1'b0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == sfa_pkg::CFG_STACK_SIZE) begin
                r_stack_size <= i_cfg_data;
            end
            if (i_cfg_idx == sfa_pkg::CFG_SEAMLESS) begin
                r_seamless <= i_cfg_data[0];
            end
        end
    end

    // Top offset and frame count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top   <= '0;
            r_count <= '0;
        end else if (i_cmd.pop_read) begin
            r_count <= count_dec;
        end else if (i_cmd.pop_finish) begin
            r_top <= rd_data;
        end else if (i_cmd.exec) begin
            case (op)
                sfa_pkg::OP_ALLOC: begin
                    if (alloc_ok) begin
                        r_top <= sum[OW-1:0];
                        if (!r_seamless) begin
                            r_count <= r_count + CW'(1);
                        end
                    end
                end
                sfa_pkg::OP_POP, sfa_pkg::OP_RELEASE: begin
                    r_top   <= '0;
                    r_count <= '0;
                end
                default: begin
                end
            endcase
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.pop_finish) begin
            r_status  <= sfa_pkg::ST_OK;
            r_offset  <= rd_data;
            r_res_top <= rd_data;
        end else if (i_cmd.exec) begin
            case (op)
                sfa_pkg::OP_ALLOC: begin
                    if (alloc_ok) begin
                        r_status  <= sfa_pkg::ST_OK;
                        r_offset  <= r_top;
                        r_res_top <= sum[OW-1:0];
                    end else begin
                        r_status  <= sfa_pkg::ST_NO_SPACE;
                        r_offset  <= '0;
                        r_res_top <= r_top;
                    end
                end
                sfa_pkg::OP_POP: begin
                    // immediate pop: seamless, or no saved frame left
                    if (!r_seamless && (r_top == '0)) begin
                        r_status <= sfa_pkg::ST_EMPTY;
                    end else begin
                        r_status <= sfa_pkg::ST_OK;
                    end
                    r_offset  <= '0;
                    r_res_top <= '0;
                end
                sfa_pkg::OP_RELEASE: begin
                    r_status  <= sfa_pkg::ST_OK;
                    r_offset  <= '0;
                    r_res_top <= '0;
                end
                default: begin
                    r_status  <= sfa_pkg::ST_OK;
                    r_offset  <= '0;
                    r_res_top <= r_top;
                end
            endcase
        end
    end

    assign o_status = r_status;
    assign o_offset = r_offset;
    assign o_top    = r_res_top;

endmodule

`default_nettype wire

>>> sv/stack_frame_allocator.sv
// Stack frame allocator: tracks the top offset of a stack region and a store
// of saved frame offsets. Allocate requests round the size up to 2^align_log2,
// charge HEADER_BYTES, return the old top and save it as a frame; pop returns
// to the last saved frame; release-all empties the stack. Seamless mode drops
// rounding, headers and frames. Requests are handled one at a time: allocate,
// release-all, an unused opcode, a seamless pop and a pop with no saved frame
// execute when accepted; any other pop restores a saved frame from the
// registered read of the frame store RAM (MAX_FRAMES entries). A result
// waiting in the output register does not block the next request unless the
// output side stalls. The frame store needs no clearing after reset, so
// requests are taken from the first cycle after reset.
`default_nettype none

module stack_frame_allocator #(
    parameter int HEADER_BYTES = 8,
    parameter int MAX_FRAMES   = 1024
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    sfa_req_if.sink                             i_req,
    sfa_rsp_if.source                           o_rsp,
    input  wire logic                           i_cfg_we,
    input  wire logic [sfa_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [sfa_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    sfa_pkg::t_cmd  cmd;
    sfa_pkg::t_stat stat;

    // Sequencing and handshakes
    sfa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // Offsets, frame store and result registers
    sfa_dp #(
        .HEADER_BYTES (HEADER_BYTES),
        .MAX_FRAMES   (MAX_FRAMES)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_opcode     (i_req.opcode),
        .i_size       (i_req.size),
        .i_align_log2 (i_req.align_log2),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .o_status     (o_rsp.status),
        .o_offset     (o_rsp.offset),
        .o_top        (o_rsp.top)
    );

endmodule

`default_nettype wire

>>> sv/sfa_chk.sv
`default_nettype none

module sfa_chk (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         i_out_valid,
    input wire logic                         i_out_ready,
    input wire logic [sfa_pkg::STATUS_W-1:0] i_status,
    input wire logic [sfa_pkg::OFFS_W-1:0]   i_offset,
    input wire logic [sfa_pkg::OFFS_W-1:0]   i_top
);

    // No response is pending right after reset
    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("response valid after reset");

    // A stalled response holds its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_status) && $stable(i_offset) && $stable(i_top))
        else $error("stalled response changed");

    // Status never carries the unused code
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_status != sfa_pkg::ST_UNUSED))
        else $error("unused status code");

    // Any failure reports a zero offset
    a_fail_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status != sfa_pkg::ST_OK) |-> (i_offset == '0))
        else $error("failure with nonzero offset");

    // An empty-stack pop leaves the top at zero
    a_empty_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == sfa_pkg::ST_EMPTY) |-> (i_top == '0))
        else $error("empty status with nonzero top");

endmodule

bind stack_frame_allocator sfa_chk u_sfa_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_status    (o_rsp.status),
    .i_offset    (o_rsp.offset),
    .i_top       (o_rsp.top)
);

`default_nettype wire
